@@ src/cst_pkg.sv @@
// Shared types, constants and helpers for the character stream tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package cst_pkg;

    // Counter widths for positions and lengths
    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 16;
    localparam int OUT_BITS = 16;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;

    // Word opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOT  = 1'b1;

    // Bytes with a role of their own
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [2:0] KW_LEN = 3'd5;

    typedef enum logic [3:0] {
        CL_UNKNOWN = 4'd0,
        CL_NUMBER  = 4'd1,
        CL_COMMENT = 4'd2,
        CL_NEWLINE = 4'd3,
        CL_SPACE   = 4'd4,
        CL_OPER    = 4'd5,
        CL_SYMBOL  = 4'd6,
        CL_KEYWORD = 4'd7,
        CL_IDENT   = 4'd8
    } tok_class_t;

    // Byte classification result
    typedef struct packed {
        logic       is_digit;
        logic       is_alpha;
        logic       is_blank;
        logic       is_nl;
        tok_class_t start_class;
    } char_info_t;

    // One emitted token
    typedef struct packed {
        tok_class_t          tok_class;
        logic [OUT_BITS-1:0] start_line;
        logic [OUT_BITS-1:0] start_col;
        logic [OUT_BITS-1:0] tok_len;
        logic                end_of_text;
    } token_t;

    // Keyword text "micro", one byte per matched position
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h6D;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h72;
            3'd4:    c = 8'h6F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Clamp a position to the output field width
    function automatic logic [OUT_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : wide[OUT_BITS-1:0];
    endfunction

    // Clamp a length to the output field width
    function automatic logic [OUT_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : wide[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/char_stream_tokenizer_unit.sv @@
// Top level of the character stream tokenizer: input word register, lexer, result register.
// Depends on cst_pkg and cst_lexer.
//
//  Channel  | Direction | tdata                                     | tuser          | tlast
//  s_axis   | in        | [7:0] chr                                 | [0] opcode     | -
//  m_axis   | out       | [15:0] start_line [31:16] start_col       | [3:0] tok_class| end_of_text
//           |           | [47:32] tok_len                           |                |
//
// One word per cycle while the result register is not stalled; a token passes the input word
// register, the lexer step and the result register after the word that closes it.
// Reset (rst_n low) puts the lexer at line 1, column 1 with no pending token.
// A stalled result holds in the result register; the input register keeps accepting
// as long as the result register is empty or being drained.
`default_nettype none

module char_stream_tokenizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] chr
    input  wire logic        s_axis_tuser,   // [0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] start_line, [31:16] start_col, [47:32] tok_len
    output logic [3:0]       m_axis_tuser,   // [3:0] tok_class
    output logic             m_axis_tlast    // end_of_text
);

    logic            in_valid_reg;
    logic            in_op_reg;
    logic [7:0]      in_chr_reg;
    logic            out_valid_reg;
    cst_pkg::token_t out_tok_reg;

    logic            advance;
    logic            step;
    logic            emit_valid;
    cst_pkg::token_t emit_tok;

    // Move the held word when the result register is free or draining
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    cst_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .opcode     (in_op_reg),
        .chr        (in_chr_reg),
        .emit_valid (emit_valid),
        .emit_tok   (emit_tok)
    );

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg  <= s_axis_tuser;
            in_chr_reg <= s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= emit_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
            out_tok_reg <= emit_tok;
    end

    // Drive the result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_tok_reg.tok_len, out_tok_reg.start_col, out_tok_reg.start_line};
    assign m_axis_tuser  = out_tok_reg.tok_class;
    assign m_axis_tlast  = out_tok_reg.end_of_text;

endmodule

`default_nettype wire

@@ src/cst_char_class.sv @@
// Byte classifier: digit, letter, blank flags and the class a token starts with.
// Depends on cst_pkg.
`default_nettype none

module cst_char_class (
    input  wire logic [7:0]          chr,
    output cst_pkg::char_info_t      info
);

    always_comb
    begin
        info.is_digit = (chr >= 8'h30) && (chr <= 8'h39);
        info.is_alpha = ((chr >= 8'h61) && (chr <= 8'h7A)) || ((chr >= 8'h41) && (chr <= 8'h5A));
        info.is_nl    = (chr == cst_pkg::CH_NL);
        info.is_blank = (chr == cst_pkg::CH_SPACE) || (chr == cst_pkg::CH_TAB) || info.is_nl;

        // Pick the class of a token opened by this byte
        if (info.is_digit)
            info.start_class = cst_pkg::CL_NUMBER;
        else if (chr == cst_pkg::CH_SEMI)
            info.start_class = cst_pkg::CL_COMMENT;
        else if (info.is_nl)
            info.start_class = cst_pkg::CL_NEWLINE;
        else if ((chr == cst_pkg::CH_SPACE) || (chr == cst_pkg::CH_TAB))
            info.start_class = cst_pkg::CL_SPACE;
        else if ((chr == cst_pkg::CH_GT) || (chr == cst_pkg::CH_LBRK) || (chr == cst_pkg::CH_RBRK))
            info.start_class = cst_pkg::CL_OPER;
        else if ((chr == cst_pkg::CH_COLON) || (chr == cst_pkg::CH_DOT))
            info.start_class = cst_pkg::CL_SYMBOL;
        else if (info.is_alpha)
            info.start_class = cst_pkg::CL_IDENT;
        else
            info.start_class = cst_pkg::CL_UNKNOWN;
    end

endmodule

`default_nettype wire

@@ src/cst_lexer.sv @@
// Token state and single-step update: grows or closes the pending token per word.
// Depends on cst_pkg and cst_char_class.
`default_nettype none

module cst_lexer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                opcode,
    input  wire logic [7:0]          chr,
    output logic                     emit_valid,
    output cst_pkg::token_t          emit_tok
);

    cst_pkg::char_info_t info;

    cst_pkg::tok_class_t               class_reg, class_next;
    logic [cst_pkg::LEN_BITS-1:0]      len_reg, len_next;
    logic [cst_pkg::POS_BITS-1:0]      tok_line_reg, tok_line_next;
    logic [cst_pkg::POS_BITS-1:0]      tok_col_reg, tok_col_next;
    logic [2:0]                        kw_matched_reg, kw_matched_next;
    logic                              kw_broken_reg, kw_broken_next;
    logic [cst_pkg::POS_BITS-1:0]      line_reg, line_next;
    logic [cst_pkg::POS_BITS-1:0]      col_reg, col_next;

    logic [cst_pkg::LEN_BITS-1:0]      len_grown;
    logic                              kw_hit;
    logic [2:0]                        kw_fed;
    logic                              kw_start_hit;
    logic                              grows;

    cst_char_class u_class (
        .chr  (chr),
        .info (info)
    );

    // Keyword tracking for a byte that continues a letter token
    assign kw_hit       = !kw_broken_reg && (kw_matched_reg < cst_pkg::KW_LEN)
                          && (chr == cst_pkg::kw_char(kw_matched_reg));
    assign kw_fed       = kw_hit ? kw_matched_reg + 3'd1 : kw_matched_reg;
    assign kw_start_hit = (chr == cst_pkg::kw_char(3'd0));
    assign len_grown    = (len_reg == cst_pkg::LEN_MAX) ? len_reg : len_reg + cst_pkg::LEN_ONE;

    // Decide whether the byte extends the pending token
    always_comb
    begin
        case (class_reg)
            cst_pkg::CL_UNKNOWN:                     grows = !info.is_blank;
            cst_pkg::CL_KEYWORD, cst_pkg::CL_IDENT:  grows = info.is_digit || info.is_alpha;
            cst_pkg::CL_COMMENT:                     grows = !info.is_nl;
            cst_pkg::CL_NUMBER:                      grows = info.is_digit;
            default:                                 grows = 1'b0;
        endcase
    end

    // Report the pending token
    always_comb
    begin
        emit_tok.tok_class   = class_reg;
        emit_tok.start_line  = cst_pkg::sat_pos(tok_line_reg);
        emit_tok.start_col   = cst_pkg::sat_pos(tok_col_reg);
        emit_tok.tok_len     = cst_pkg::sat_len(len_reg);
        emit_tok.end_of_text = (opcode == cst_pkg::OP_EOT);
        emit_valid = step && (len_reg != cst_pkg::LEN_ZERO)
                     && ((opcode == cst_pkg::OP_EOT) || !grows);
    end

    // Next state
    always_comb
    begin
        class_next      = class_reg;
        len_next        = len_reg;
        tok_line_next   = tok_line_reg;
        tok_col_next    = tok_col_reg;
        kw_matched_next = kw_matched_reg;
        kw_broken_next  = kw_broken_reg;
        line_next       = line_reg;
        col_next        = col_reg;

        if (opcode == cst_pkg::OP_EOT)
        begin
            // Flush and return to the reset state
            class_next      = cst_pkg::CL_UNKNOWN;
            len_next        = cst_pkg::LEN_ZERO;
            tok_line_next   = cst_pkg::POS_ONE;
            tok_col_next    = cst_pkg::POS_ONE;
            kw_matched_next = 3'd0;
            kw_broken_next  = 1'b0;
            line_next       = cst_pkg::POS_ONE;
            col_next        = cst_pkg::POS_ONE;
        end
        else
        begin
            if ((len_reg == cst_pkg::LEN_ZERO) || !grows)
            begin
                // Open a new token at the current position
                tok_line_next   = line_reg;
                tok_col_next    = col_reg;
                len_next        = cst_pkg::LEN_ONE;
                kw_matched_next = 3'd0;
                kw_broken_next  = 1'b0;
                class_next      = info.start_class;
                if (info.is_alpha)
                begin
                    kw_matched_next = kw_start_hit ? 3'd1 : 3'd0;
                    kw_broken_next  = !kw_start_hit;
                    class_next      = cst_pkg::CL_IDENT;
                end
            end
            else
            begin
                // Grow the pending token
                len_next = len_grown;
                if (class_reg == cst_pkg::CL_UNKNOWN)
                begin
                    if (info.is_digit || info.is_alpha)
                    begin
                        kw_broken_next = 1'b1;
                        class_next     = cst_pkg::CL_IDENT;
                    end
                end
                else if ((class_reg == cst_pkg::CL_KEYWORD) || (class_reg == cst_pkg::CL_IDENT))
                begin
                    kw_matched_next = kw_fed;
                    kw_broken_next  = !kw_hit;
                    class_next      = (kw_hit && (kw_fed == cst_pkg::KW_LEN))
                                      ? cst_pkg::CL_KEYWORD : cst_pkg::CL_IDENT;
                end
            end

            // Advance the source position
            if (info.is_nl)
            begin
                col_next = cst_pkg::POS_ONE;
                if (line_reg != cst_pkg::POS_MAX)
                    line_next = line_reg + cst_pkg::POS_ONE;
            end
            else if (col_reg != cst_pkg::POS_MAX)
            begin
                col_next = col_reg + cst_pkg::POS_ONE;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg      <= cst_pkg::CL_UNKNOWN;
            len_reg        <= cst_pkg::LEN_ZERO;
            tok_line_reg   <= cst_pkg::POS_ONE;
            tok_col_reg    <= cst_pkg::POS_ONE;
            kw_matched_reg <= 3'd0;
            kw_broken_reg  <= 1'b0;
            line_reg       <= cst_pkg::POS_ONE;
            col_reg        <= cst_pkg::POS_ONE;
        end
        else if (step)
        begin
            class_reg      <= class_next;
            len_reg        <= len_next;
            tok_line_reg   <= tok_line_next;
            tok_col_reg    <= tok_col_next;
            kw_matched_reg <= kw_matched_next;
            kw_broken_reg  <= kw_broken_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for char_stream_tokenizer_unit: a behavioral token predictor,
// a stream sender with random gaps and a stalling sink that checks every token word.
// Depends on cst_pkg and the tokenizer RTL.
`default_nettype none

module tb_top;

    localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake before giving up
    localparam int HOLD_CYCLES  = 80;     // long sink stall for the back-pressure test
    localparam int TAIL_CYCLES  = 8;      // settle time after the last expected token
    localparam int BURST_RUN    = 60;     // comment body sent back to back
    localparam int BURST_LINES  = 20;     // newlines sent back to back
    localparam logic [39:0] KW_TEXT = "micro";

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] chr
    logic        s_axis_tuser = 1'b0;    // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [15:0] start_line, [31:16] start_col, [47:32] tok_len
    logic [3:0]  m_axis_tuser;           // [3:0] tok_class
    logic        m_axis_tlast;           // end_of_text

    // Lexer state mirrored by the predictor
    cst_pkg::tok_class_t          cur_kind;
    logic [cst_pkg::LEN_BITS-1:0] cur_bytes;
    logic [cst_pkg::POS_BITS-1:0] head_line;
    logic [cst_pkg::POS_BITS-1:0] head_col;
    logic [cst_pkg::POS_BITS-1:0] line_pos;
    logic [cst_pkg::POS_BITS-1:0] col_pos;
    logic [2:0]                   kw_hits;
    logic                         kw_miss;

    cst_pkg::token_t expected_tokens[$];

    int  words_sent     = 0;
    int  tokens_checked = 0;
    int  errors         = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;
    bit  hold_sink      = 1'b0;

    char_stream_tokenizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_alnum(input logic [7:0] c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic void clear_lexer();
        cur_kind  = cst_pkg::CL_UNKNOWN;
        cur_bytes = cst_pkg::LEN_ZERO;
        head_line = cst_pkg::POS_ONE;
        head_col  = cst_pkg::POS_ONE;
        line_pos  = cst_pkg::POS_ONE;
        col_pos   = cst_pkg::POS_ONE;
        kw_hits   = 3'd0;
        kw_miss   = 1'b0;
    endfunction

    function automatic void lengthen();
        if (cur_bytes != cst_pkg::LEN_MAX)
            cur_bytes++;
    endfunction

    // Track progress against the keyword; any slip makes it a plain identifier
    function automatic void feed_keyword(input logic [7:0] c);
        if (!kw_miss && kw_hits < cst_pkg::KW_LEN && c == KW_TEXT[8 * (4 - int'(kw_hits)) +: 8])
            kw_hits++;
        else
            kw_miss = 1'b1;
        cur_kind = (!kw_miss && kw_hits == cst_pkg::KW_LEN) ? cst_pkg::CL_KEYWORD
                                                            : cst_pkg::CL_IDENT;
    endfunction

    function automatic void open_token(input logic [7:0] c);
        head_line = line_pos;
        head_col  = col_pos;
        cur_bytes = cst_pkg::LEN_ONE;
        kw_hits   = 3'd0;
        kw_miss   = 1'b0;
        if (is_digit(c))
            cur_kind = cst_pkg::CL_NUMBER;
        else if (c == cst_pkg::CH_SEMI)
            cur_kind = cst_pkg::CL_COMMENT;
        else if (c == cst_pkg::CH_NL)
            cur_kind = cst_pkg::CL_NEWLINE;
        else if (c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB)
            cur_kind = cst_pkg::CL_SPACE;
        else if (c == cst_pkg::CH_GT || c == cst_pkg::CH_LBRK || c == cst_pkg::CH_RBRK)
            cur_kind = cst_pkg::CL_OPER;
        else if (c == cst_pkg::CH_COLON || c == cst_pkg::CH_DOT)
            cur_kind = cst_pkg::CL_SYMBOL;
        else if (is_alpha(c))
            feed_keyword(c);
        else
            cur_kind = cst_pkg::CL_UNKNOWN;
    endfunction

    // Grow the pending token by one byte; return 0 when the byte closes it
    function automatic bit absorb_byte(input logic [7:0] c);
        case (cur_kind)
            cst_pkg::CL_UNKNOWN:
            begin
                if (is_alnum(c))
                begin
                    lengthen();
                    kw_miss  = 1'b1;
                    cur_kind = cst_pkg::CL_IDENT;
                    return 1'b1;
                end
                if (c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB || c == cst_pkg::CH_NL)
                    return 1'b0;
                lengthen();
                return 1'b1;
            end
            cst_pkg::CL_KEYWORD, cst_pkg::CL_IDENT:
            begin
                if (!is_alnum(c))
                    return 1'b0;
                lengthen();
                feed_keyword(c);
                return 1'b1;
            end
            cst_pkg::CL_COMMENT:
            begin
                if (c == cst_pkg::CH_NL)
                    return 1'b0;
                lengthen();
                return 1'b1;
            end
            cst_pkg::CL_NUMBER:
            begin
                if (!is_digit(c))
                    return 1'b0;
                lengthen();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void push_token(input logic eot);
        cst_pkg::token_t t;
        t.tok_class   = cur_kind;
        t.start_line  = head_line;
        t.start_col   = head_col;
        t.tok_len     = cur_bytes;
        t.end_of_text = eot;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void predict_token(input logic op, input logic [7:0] c);
        if (op == cst_pkg::OP_EOT)
        begin
            if (cur_bytes != cst_pkg::LEN_ZERO)
                push_token(1'b1);
            clear_lexer();
            return;
        end
        if (cur_bytes == cst_pkg::LEN_ZERO)
            open_token(c);
        else if (!absorb_byte(c))
        begin
            push_token(1'b0);
            open_token(c);
        end
        // Advance the running position, saturating
        if (c == cst_pkg::CH_NL)
        begin
            col_pos = cst_pkg::POS_ONE;
            if (line_pos != cst_pkg::POS_MAX)
                line_pos++;
        end
        else if (col_pos != cst_pkg::POS_MAX)
            col_pos++;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one word after a random gap; valid stays high when the gap is zero
    task automatic send_word(input logic op, input logic [7:0] c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= c;
        do @(posedge clk); while (!s_axis_tready);
        predict_token(op, c);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(cst_pkg::OP_CHAR, s[i]);
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9)) : rand_alpha();
    endfunction

    // One random piece of source text, mostly well-formed lexemes
    task automatic send_fragment();
        int kind;
        int n;
        logic [7:0] c;
        logic [7:0] marks[5];
        marks = '{cst_pkg::CH_GT, cst_pkg::CH_LBRK, cst_pkg::CH_RBRK, cst_pkg::CH_COLON,
                  cst_pkg::CH_DOT};
        kind = $urandom_range(0, 19);
        if (kind <= 5)
        begin
            // Identifier or keyword, with near misses of the keyword
            n = $urandom_range(0, 3);
            if (n == 0)
                send_text("micro");
            else if (n == 1)
                send_text("mic");
            else
                send_word(cst_pkg::OP_CHAR, rand_alpha());
            repeat ($urandom_range(0, 4) * ($urandom_range(0, 2) == 0 ? 0 : 1))
                send_word(cst_pkg::OP_CHAR, rand_alnum());
        end
        else if (kind <= 8)
        begin
            repeat ($urandom_range(1, 6))
                send_word(cst_pkg::OP_CHAR, 8'("0" + $urandom_range(0, 9)));
        end
        else if (kind <= 10)
        begin
            send_word(cst_pkg::OP_CHAR, cst_pkg::CH_SEMI);
            repeat ($urandom_range(0, 10))
            begin
                c = 8'($urandom_range(0, 255));
                send_word(cst_pkg::OP_CHAR, (c == cst_pkg::CH_NL) ? cst_pkg::CH_SPACE : c);
            end
            send_word(cst_pkg::OP_CHAR, cst_pkg::CH_NL);
        end
        else if (kind <= 13)
        begin
            repeat ($urandom_range(1, 3))
            begin
                n = $urandom_range(0, 2);
                send_word(cst_pkg::OP_CHAR, (n == 0) ? cst_pkg::CH_SPACE :
                                            (n == 1) ? cst_pkg::CH_TAB : cst_pkg::CH_NL);
            end
        end
        else if (kind <= 15)
            send_word(cst_pkg::OP_CHAR, marks[$urandom_range(0, 4)]);
        else if (kind <= 18)
        begin
            repeat ($urandom_range(1, 3))
                send_word(cst_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        end
        else
            send_word(cst_pkg::OP_EOT, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Sink side: random stalls, one long hold on request, field checks
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_token();
        cst_pkg::token_t want;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected token, expected none, actual class %0d line %0d col %0d len %0d",
                     $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                     m_axis_tdata[47:32]);
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        compare_field("tok_class", 16'(want.tok_class), 16'(m_axis_tuser));
        compare_field("start_line", want.start_line, m_axis_tdata[15:0]);
        compare_field("start_col", want.start_col, m_axis_tdata[31:16]);
        compare_field("tok_len", want.tok_len, m_axis_tdata[47:32]);
        compare_field("end_of_text", 16'(want.end_of_text), 16'(m_axis_tlast));
    endtask

    initial
    begin : token_sink
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_sink = 1'b0;
            end
            else
            begin
                stall = rx_idle ? $urandom_range(0, 4) : 0;
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            check_token();
        end
    end

    // Stop a hung run: no handshake on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every token class, unknown growth, odd bytes and both end-of-text cases
    task automatic test_directed();
        send_text("micro;");
        send_word(cst_pkg::OP_CHAR, cst_pkg::CH_NL);
        send_text("7z$a ");
        send_word(cst_pkg::OP_CHAR, 8'h80);
        send_word(cst_pkg::OP_CHAR, cst_pkg::CH_TAB);
        send_text(">[]:.");
        send_word(cst_pkg::OP_CHAR, 8'hFF);
        send_text("#");
        send_word(cst_pkg::OP_EOT, 8'h00);
        send_word(cst_pkg::OP_EOT, 8'hFF);
    endtask

    task automatic test_random_text(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
            send_fragment();
    endtask

    // Sink stalls for a long stretch while words keep coming
    task automatic test_backpressure();
        int stop_at;
        stop_at = words_sent + 150;
        hold_sink = 1'b1;
        while (words_sent < stop_at)
            send_fragment();
    endtask

    // Run words back to back on both sides: a long comment, blank lines and flushes
    task automatic test_burst();
        logic [7:0] c;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_word(cst_pkg::OP_CHAR, cst_pkg::CH_SEMI);
        repeat (BURST_RUN)
        begin
            c = 8'($urandom_range(0, 255));
            send_word(cst_pkg::OP_CHAR, (c == cst_pkg::CH_NL) ? cst_pkg::CH_DOT : c);
        end
        repeat (BURST_LINES)
            send_word(cst_pkg::OP_CHAR, cst_pkg::CH_NL);
        send_text("ab7 ");
        send_word(cst_pkg::OP_EOT, 8'h00);
        // Positions must be back at the start after the flush
        send_text("q");
        send_word(cst_pkg::OP_EOT, 8'h00);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        clear_lexer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(1250);
        test_backpressure();
        test_burst();
        test_random_text(100);

        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words and checked %0d tokens across all classes,", words_sent,
                 tokens_checked);
        $display("random gaps and stalls, a long sink hold and gap-free bursts with flushes.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
src/cst_pkg.sv
src/cst_char_class.sv
src/cst_lexer.sv
src/char_stream_tokenizer_unit.sv
tb/sv/tb_top.sv
